// ===== src/twt_pkg.sv =====
// Shared constants, codes and types for the timing-wheel timer engine.
// Used by twt_wrap_add, twt_table and timing_wheel_timer_engine; depends on nothing.
package twt_pkg;

    localparam int WHEEL_SLOTS = 60;
    localparam int NUM_TIMERS  = 16;

    localparam int POS_W  = (WHEEL_SLOTS > 1) ? $clog2(WHEEL_SLOTS) : 1;
    localparam int TIDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int REQ_W  = 3;
    localparam int ID_W   = 4;
    localparam int TMO_W  = 6;
    localparam int WPOS_W = 6;

    localparam logic [REQ_W-1:0] REQ_ADD     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_REFRESH = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CANCEL  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_TICK    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_QUERY   = 3'd4;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_REJECT  = 3'd1,
        ST_UNKNOWN = 3'd2,
        ST_FIRED   = 3'd3,
        ST_SILENT  = 3'd4,
        ST_TICK    = 3'd5
    } status_t;

    // Table write command: one entry per cycle
    typedef struct packed {
        logic              set_valid;
        logic              clr_valid;
        logic              set_cancel;
        logic              clr_cancel;
        logic              wr_timeout;
        logic              wr_deadline;
        logic [TIDX_W-1:0] idx;
        logic [TMO_W-1:0]  timeout;
        logic [POS_W-1:0]  deadline;
    } twt_wr_t;

    // Table read view of one entry
    typedef struct packed {
        logic             valid;
        logic             cancelled;
        logic [TMO_W-1:0] timeout;
        logic [POS_W-1:0] deadline;
    } twt_rd_t;

endpackage

// ===== src/twt_wrap_add.sv =====
// Shared modular adder: (base + offset) mod WHEEL_SLOTS for operands below WHEEL_SLOTS.
// Depends on twt_pkg.
module twt_wrap_add
    import twt_pkg::*;
(
    input  logic [POS_W-1:0] base,
    input  logic [TMO_W-1:0] offset,
    output logic [POS_W-1:0] sum
);

    localparam int SUM_W = ((POS_W > TMO_W) ? POS_W : TMO_W) + 1;

    logic [SUM_W-1:0] raw;
    logic [SUM_W-1:0] wrapped;

    // Both operands stay below the wheel size, so one subtract folds the sum.
    assign raw     = SUM_W'(base) + SUM_W'(offset);
    assign wrapped = (raw >= SUM_W'(WHEEL_SLOTS)) ? raw - SUM_W'(WHEEL_SLOTS) : raw;
    assign sum     = POS_W'(wrapped);

endmodule

// ===== src/twt_table.sv =====
// Timer entry table: valid and cancel flags in flops, timeout and deadline per entry.
// Depends on twt_pkg.
module twt_table
    import twt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  twt_wr_t           wr,
    input  logic [TIDX_W-1:0] rd_idx,
    output twt_rd_t           rd
);

    logic [NUM_TIMERS-1:0] valid_reg;
    logic [NUM_TIMERS-1:0] cancel_reg;
    logic [TMO_W-1:0]      timeout_reg  [NUM_TIMERS];
    logic [POS_W-1:0]      deadline_reg [NUM_TIMERS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            cancel_reg <= '0;
        end
        else
        begin
            if (wr.set_valid)
                valid_reg[wr.idx] <= 1'b1;
            else if (wr.clr_valid)
                valid_reg[wr.idx] <= 1'b0;
            if (wr.set_cancel)
                cancel_reg[wr.idx] <= 1'b1;
            else if (wr.clr_cancel)
                cancel_reg[wr.idx] <= 1'b0;
        end
    end

    // Payload fields carry no reset; their values are only used for valid entries.
    always_ff @(posedge clk)
    begin
        if (wr.wr_timeout)
            timeout_reg[wr.idx] <= wr.timeout;
        if (wr.wr_deadline)
            deadline_reg[wr.idx] <= wr.deadline;
    end

    assign rd.valid     = valid_reg[rd_idx];
    assign rd.cancelled = cancel_reg[rd_idx];
    assign rd.timeout   = timeout_reg[rd_idx];
    assign rd.deadline  = deadline_reg[rd_idx];

endmodule

// ===== src/timing_wheel_timer_engine.sv =====
// Timing-wheel timer engine top level: sequencer, output register and assertions.
// Depends on twt_pkg, twt_wrap_add and twt_table.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid, in_stall, req_type, timer_id,          | in
//          | timeout_ticks                                   |
//  out     | out_valid, out_stall, status, result_id,         | out
//          | present, wheel_position, last                   |
//  cfg     | cfg_wr_en, cfg_wr_data (max_timeout)            | in
//
// An add, refresh, cancel or query word is accepted and then runs an execute step
// through the shared modular adder. A tick word is accepted, then computes the
// advanced position, then walks the table entries in order on the deadline
// comparator, and ends with the closing word.
// Reset clears the position, the valid and cancel flags and the output valid flag;
// max_timeout resets to 59. A stalled output register holds the sequencer in
// place, and no new input word is taken until the current one has finished.
module timing_wheel_timer_engine
    import twt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic [REQ_W-1:0]  req_type,
    input  logic [ID_W-1:0]   timer_id,
    input  logic [TMO_W-1:0]  timeout_ticks,

    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        status,
    output logic [ID_W-1:0]   result_id,
    output logic              present,
    output logic [WPOS_W-1:0] wheel_position,
    output logic              last,

    input  logic              cfg_wr_en,
    input  logic [TMO_W-1:0]  cfg_wr_data
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_ADV  = 5'b00100,
        S_SCAN = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t            state_reg,    state_next;
    logic [REQ_W-1:0]  req_reg,      req_next;
    logic [ID_W-1:0]   id_reg,       id_next;
    logic [TMO_W-1:0]  tmo_reg,      tmo_next;
    logic [POS_W-1:0]  pos_reg,      pos_next;
    logic [POS_W-1:0]  adv_pos_reg,  adv_pos_next;
    logic [TIDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic [TMO_W-1:0]  max_tmo_reg;

    logic              out_valid_reg,   out_valid_next;
    status_t           out_status_reg,  out_status_next;
    logic [ID_W-1:0]   out_id_reg,      out_id_next;
    logic              out_present_reg, out_present_next;
    logic [POS_W-1:0]  out_pos_reg,     out_pos_next;
    logic              out_last_reg,    out_last_next;

    logic              in_accept;
    logic              out_free;
    logic              in_range;
    logic              tmo_reject;
    logic              hit;
    logic              scan_end;

    logic [POS_W-1:0]  add_base;
    logic [TMO_W-1:0]  add_offset;
    logic [POS_W-1:0]  add_sum;

    logic [TIDX_W-1:0] rd_idx;
    twt_rd_t           rd;
    twt_wr_t           wr;

    // One modular adder serves both the deadline computation and the advance.
    twt_wrap_add u_add (
        .base   (add_base),
        .offset (add_offset),
        .sum    (add_sum)
    );

    twt_table u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (wr),
        .rd_idx (rd_idx),
        .rd     (rd)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    // Output register may take a new word when empty or being drained this cycle
    assign out_free  = !out_valid_reg || !out_stall;

    assign in_range   = (int'(id_reg) < NUM_TIMERS);
    // Effective limit is the smaller of max_timeout and the wheel size minus one
    assign tmo_reject = (tmo_reg > max_tmo_reg) || (int'(tmo_reg) > WHEEL_SLOTS - 1);

    // Scan walks the table; requests address the entry named by the id
    assign rd_idx   = (state_reg == S_SCAN) ? scan_idx_reg : TIDX_W'(id_reg);
    assign hit      = rd.valid && (rd.deadline == pos_reg);
    assign scan_end = (scan_idx_reg == TIDX_W'(NUM_TIMERS - 1));

    assign add_base   = pos_reg;
    assign add_offset = (state_reg == S_ADV) ? TMO_W'(1) :
                        (req_reg == REQ_ADD) ? tmo_reg : rd.timeout;

    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        id_next          = id_reg;
        tmo_next         = tmo_reg;
        pos_next         = pos_reg;
        adv_pos_next     = adv_pos_reg;
        scan_idx_next    = scan_idx_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_status_next  = out_status_reg;
        out_id_next      = out_id_reg;
        out_present_next = out_present_reg;
        out_pos_next     = out_pos_reg;
        out_last_next    = out_last_reg;

        wr          = '0;
        wr.idx      = TIDX_W'(id_reg);
        wr.timeout  = tmo_reg;
        wr.deadline = add_sum;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    req_next   = req_type;
                    id_next    = timer_id;
                    tmo_next   = timeout_ticks;
                    state_next = (req_type == REQ_TICK) ? S_ADV : S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_id_next      = id_reg;
                    out_pos_next     = pos_reg;
                    out_last_next    = 1'b1;
                    out_status_next  = ST_OK;
                    out_present_next = in_range && rd.valid;
                    case (req_reg)
                        REQ_ADD:
                        begin
                            if (!in_range)
                                out_status_next = ST_UNKNOWN;
                            else if (tmo_reject)
                                out_status_next = ST_REJECT;
                            else
                            begin
                                wr.set_valid     = 1'b1;
                                wr.clr_cancel    = 1'b1;
                                wr.wr_timeout    = 1'b1;
                                wr.wr_deadline   = 1'b1;
                                out_present_next = 1'b1;
                            end
                        end
                        REQ_REFRESH:
                        begin
                            if (!in_range || !rd.valid)
                                out_status_next = ST_UNKNOWN;
                            else
                                wr.wr_deadline = 1'b1;
                        end
                        REQ_CANCEL:
                        begin
                            if (!in_range || !rd.valid)
                                out_status_next = ST_UNKNOWN;
                            else
                                wr.set_cancel = 1'b1;
                        end
                        default:
                        begin
                            // query and unused codes: report presence only
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end

            S_ADV:
            begin
                // Compute the advanced position once; expiry words report it
                adv_pos_next  = add_sum;
                scan_idx_next = '0;
                state_next    = S_SCAN;
            end

            S_SCAN:
            begin
                if (!hit || out_free)
                begin
                    if (hit)
                    begin
                        wr.idx           = scan_idx_reg;
                        wr.clr_valid     = 1'b1;
                        wr.clr_cancel    = 1'b1;
                        out_valid_next   = 1'b1;
                        out_status_next  = rd.cancelled ? ST_SILENT : ST_FIRED;
                        out_id_next      = ID_W'(scan_idx_reg);
                        out_present_next = 1'b0;
                        out_pos_next     = adv_pos_reg;
                        out_last_next    = 1'b0;
                    end
                    if (scan_end)
                        state_next = S_DONE;
                    else
                        scan_idx_next = scan_idx_reg + 1'b1;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    pos_next         = adv_pos_reg;
                    out_valid_next   = 1'b1;
                    out_status_next  = ST_TICK;
                    out_id_next      = '0;
                    out_present_next = 1'b0;
                    out_pos_next     = adv_pos_reg;
                    out_last_next    = 1'b1;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            max_tmo_reg   <= TMO_W'(59);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                max_tmo_reg <= cfg_wr_data;
        end
    end

    // Hold request and output payload without reset
    always_ff @(posedge clk)
    begin
        req_next_hold: begin end
        req_reg         <= req_next;
        id_reg          <= id_next;
        tmo_reg         <= tmo_next;
        adv_pos_reg     <= adv_pos_next;
        scan_idx_reg    <= scan_idx_next;
        out_status_reg  <= out_status_next;
        out_id_reg      <= out_id_next;
        out_present_reg <= out_present_next;
        out_pos_reg     <= out_pos_next;
        out_last_reg    <= out_last_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign result_id      = out_id_reg;
    assign present        = out_present_reg;
    assign wheel_position = WPOS_W'(out_pos_reg);
    assign last           = out_last_reg;

`ifndef NO_ASSERTIONS
    // An accepted tick word must start with the position advance step
    a_tick_starts_adv: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && req_type == REQ_TICK) |=> (state_reg == S_ADV))
        else $error("tick word did not enter the advance step");

    // The wheel position never leaves the wheel
    a_pos_in_wheel: assert property (@(posedge clk) disable iff (!rst_n)
        int'(pos_reg) < WHEEL_SLOTS)
        else $error("wheel position out of range");

    // Expiry words are never final and always report the timer as gone
    a_expiry_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_FIRED || status == ST_SILENT)) |-> (!last && !present))
        else $error("expiry word with last or present set");

    // A stalled output word holds its contents into the next cycle
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(result_id)))
        else $error("stalled output word changed");
`endif

endmodule
